// ===== rtl/escaped_string_decoder_macros.svh =====
// Assertion helpers for the decoder RTL.
`ifndef ESCAPED_STRING_DECODER_MACROS_SVH
`define ESCAPED_STRING_DECODER_MACROS_SVH

// Checked only outside reset.
`define ESD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define ESD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/esd_pkg.sv =====
package esd_pkg;

   typedef enum logic [4:0] {
      PH_START = 5'b00001,
      PH_BODY  = 5'b00010,
      PH_ESC   = 5'b00100,
      PH_HEX1  = 5'b01000,
      PH_HEX2  = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      ST_BYTE   = 3'd0,
      ST_DONE   = 3'd1,
      ST_ENDESC = 3'd2,
      ST_HEXCUT = 3'd3,
      ST_BADHEX = 3'd4,
      ST_UNKESC = 3'd5,
      ST_UNTERM = 3'd6
   } status_type;

   localparam logic [7:0] CLOSE_RESET = 8'h22;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_BSL   = 8'h5C;
   localparam logic [7:0] CHAR_N     = 8'h6E;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_F     = 8'h66;

   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_NUL = 8'h00;
   localparam logic [7:0] CODE_BEL = 8'h07;
   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] nib;
      logic       nib_ok;
   } state_type;

   typedef struct packed {
      logic       emit;
      status_type status;
      logic [7:0] data;
   } result_type;

   function automatic logic is_hex(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   // letters in either case have low nibble 1..6
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         v = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// ===== rtl/esd_decode.sv =====
module esd_decode (
   input  esd_pkg::state_type  cur,
   input  logic [7:0]          src_byte,
   input  logic                stream_end,
   input  logic [7:0]          close_char,
   output esd_pkg::state_type  nxt,
   output esd_pkg::result_type res
);
   import esd_pkg::*;

   state_type  body_nxt;
   result_type body_res;
   state_type  idle_state;

   assign idle_state = '{phase: PH_START, nib: 4'd0, nib_ok: 1'b0};

   // body handling, also used for a non-space first byte
   always_comb begin
      body_nxt = '{phase: PH_BODY, nib: cur.nib, nib_ok: cur.nib_ok};
      body_res = '{emit: 1'b1, status: ST_BYTE, data: src_byte};
      if (stream_end) begin
         body_nxt = idle_state;
         body_res = '{emit: 1'b1, status: ST_UNTERM, data: 8'd0};
      end else if (src_byte == close_char) begin
         body_nxt = idle_state;
         body_res = '{emit: 1'b1, status: ST_DONE, data: 8'd0};
      end else if (src_byte == CHAR_BSL) begin
         body_nxt.phase = PH_ESC;
         body_res.emit  = 1'b0;
      end
   end

   always_comb begin
      nxt = cur;
      res = '{emit: 1'b0, status: ST_BYTE, data: 8'd0};
      case (cur.phase)
         PH_BODY: begin
            nxt = body_nxt;
            res = body_res;
         end
         PH_ESC: begin
            res.emit  = 1'b1;
            nxt.phase = PH_BODY;
            if (stream_end) begin
               nxt        = idle_state;
               res.status = ST_ENDESC;
            end else begin
               // escape letters take priority over the close byte
               case (src_byte)
                  CHAR_N:    res.data = CODE_LF;
                  CHAR_R:    res.data = CODE_CR;
                  CHAR_T:    res.data = CODE_TAB;
                  CHAR_ZERO: res.data = CODE_NUL;
                  CHAR_A:    res.data = CODE_BEL;
                  CHAR_B:    res.data = CODE_BS;
                  CHAR_F:    res.data = CODE_FF;
                  CHAR_BSL:  res.data = CHAR_BSL;
                  CHAR_PCT: begin
                     res.emit  = 1'b0;
                     nxt.phase = PH_HEX1;
                  end
                  default: begin
                     if (src_byte == close_char) begin
                        res.data = close_char;
                     end else begin
                        nxt        = idle_state;
                        res.status = ST_UNKESC;
                     end
                  end
               endcase
            end
         end
         PH_HEX1: begin
            if (stream_end) begin
               nxt = idle_state;
               res = '{emit: 1'b1, status: ST_HEXCUT, data: 8'd0};
            end else begin
               nxt = '{phase: PH_HEX2, nib: hex_value(src_byte),
                       nib_ok: is_hex(src_byte)};
            end
         end
         PH_HEX2: begin
            nxt      = idle_state;
            res.emit = 1'b1;
            if (stream_end) begin
               res.status = ST_HEXCUT;
            end else if (!cur.nib_ok || !is_hex(src_byte)) begin
               res.status = ST_BADHEX;
            end else begin
               nxt.phase = PH_BODY;
               res.data  = {cur.nib, hex_value(src_byte)};
            end
         end
         default: begin
            // start of string; unknown codes land here too
            if (!stream_end && src_byte == CHAR_SPACE) begin
               nxt.phase = PH_BODY;
            end else begin
               nxt = body_nxt;
               res = body_res;
            end
         end
      endcase
   end

endmodule

// ===== rtl/escaped_string_decoder.sv =====
// Backslash-escape string decoder. Each request carries one source byte
// (req_tdata) or, with req_tuser high, the end of the source. A leading space
// is dropped, the byte in csr_wdata (reset 0x22) closes the string, and the
// escapes \n \r \t \0 \a \b \f \\, \<close> and \%HH are expanded. Each
// request gives zero or one response: a data byte with rsp_tuser = 0, or a
// status (1 done, 2 end after backslash, 3 hex cut short, 4 bad hex,
// 5 unknown escape, 6 unterminated) with rsp_tdata = 0, after which a new
// string begins. One request is taken per cycle while the response slot is free
// or being read; a request is held in the input register, and then the single
// decode stage, which also updates the escape state, writes its response into the response register.
// Write the close byte only while no request is in flight.
module escaped_string_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] src_byte
   input  logic       req_tuser,   // [0] stream_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [2:0] status
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import esd_pkg::*;

   `include "escaped_string_decoder_macros.svh"

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_end_ff, s1_end_in;
   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [7:0] close_ff, close_in;

   state_type  dec_nxt;
   result_type dec_res;
   logic       s1_adv;
   logic       req_take;

   esd_decode u_decode (
      .cur        (state_ff),
      .src_byte   (s1_byte_ff),
      .stream_end (s1_end_ff),
      .close_char (close_ff),
      .nxt        (dec_nxt),
      .res        (dec_res)
   );

   // the staged request moves on unless it needs the response slot and that is full and not being read
   assign s1_adv     = s1_valid_ff && (!dec_res.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      s1_end_in     = s1_end_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      close_in      = csr_we ? csr_wdata : close_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in = 1'b0;
         state_in    = dec_nxt;
         if (dec_res.emit) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = dec_res.data;
            rsp_status_in = dec_res.status;
         end
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_end_in   = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_START, nib: 4'd0, nib_ok: 1'b0};
         close_ff     <= CLOSE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         close_ff     <= close_in;
      end
      s1_byte_ff    <= s1_byte_in;
      s1_end_ff     <= s1_end_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `ESD_ASSERT_ALWAYS(a_reset_empty, reset |=> !s1_valid_ff && !rsp_valid_ff, "pipe not empty after reset")
   `ESD_ASSERT(a_stall_held, !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready, "input stalled without cause")
   `ESD_ASSERT(a_status_zero, rsp_valid_ff && rsp_status_ff != ST_BYTE |-> rsp_data_ff == 8'd0, "status response carries data")
   `ESD_ASSERT(a_term_restart, s1_adv && dec_res.emit && dec_res.status != ST_BYTE |=> state_ff.phase == PH_START, "no new string after status")
   `ESD_ASSERT(a_byte_body, s1_adv && dec_res.emit && dec_res.status == ST_BYTE |=> state_ff.phase == PH_BODY, "data byte left string body")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import esd_pkg::*;

   localparam int unsigned DRAIN_CYCLES = 6;    // two-stage pipe plus margin
   localparam int unsigned STALL_LIMIT  = 4000; // cycles with no handshake at all

   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] UPPER_A   = 8'h41;
   localparam logic [7:0] UPPER_F   = 8'h46;

   typedef struct packed {
      status_type status;
      logic [7:0] data;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] src_byte
   logic       req_tuser = 1'b0;    // [0] stream_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [2:0] rsp_tuser;           // [2:0] status
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'h00;

   // decoder shadow state
   phase_type   dec_phase   = PH_START;
   logic [3:0]  dec_nib     = 4'd0;
   logic        dec_nib_ok  = 1'b0;
   logic [7:0]  dec_close   = CLOSE_RESET;
   decoded_type decoded_q[$];

   bit          idle_on = 1'b1;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned close_writes;
   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned status_hits [8];

   escaped_string_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // {valid, value} of a hex digit character
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b1, 4'(c - CHAR_ZERO)};
      if (c >= CHAR_A && c <= CHAR_F) return {1'b1, 4'(c - CHAR_A + 8'd10)};
      if (c >= UPPER_A && c <= UPPER_F) return {1'b1, 4'(c - UPPER_A + 8'd10)};
      return 5'b0;
   endfunction

   function automatic void push_decoded(input status_type st, input logic [7:0] d);
      decoded_type r;
      r.status = st;
      r.data   = d;
      decoded_q.push_back(r);
      if (st != ST_BYTE) begin
         dec_phase  = PH_START;
         dec_nib    = 4'd0;
         dec_nib_ok = 1'b0;
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic fin);
      phase_type  ph;
      logic [4:0] hx;
      ph = dec_phase;
      if (ph == PH_START) begin
         if (fin) begin
            push_decoded(ST_UNTERM, 8'h00);
            return;
         end
         if (b == CHAR_SPACE) begin
            dec_phase = PH_BODY;
            return;
         end
         ph = PH_BODY;
      end
      if (ph == PH_BODY) begin
         if (fin) push_decoded(ST_UNTERM, 8'h00);
         else if (b == dec_close) push_decoded(ST_DONE, 8'h00);
         else if (b == CHAR_BSL) dec_phase = PH_ESC;
         else begin
            dec_phase = PH_BODY;
            push_decoded(ST_BYTE, b);
         end
      end else if (ph == PH_ESC) begin
         if (fin) push_decoded(ST_ENDESC, 8'h00);
         else begin
            dec_phase = PH_BODY;
            // escape letters win over the close byte
            case (b)
               CHAR_N:    push_decoded(ST_BYTE, CODE_LF);
               CHAR_R:    push_decoded(ST_BYTE, CODE_CR);
               CHAR_T:    push_decoded(ST_BYTE, CODE_TAB);
               CHAR_ZERO: push_decoded(ST_BYTE, CODE_NUL);
               CHAR_A:    push_decoded(ST_BYTE, CODE_BEL);
               CHAR_B:    push_decoded(ST_BYTE, CODE_BS);
               CHAR_F:    push_decoded(ST_BYTE, CODE_FF);
               CHAR_BSL:  push_decoded(ST_BYTE, CHAR_BSL);
               CHAR_PCT:  dec_phase = PH_HEX1;
               default: begin
                  if (b == dec_close) push_decoded(ST_BYTE, dec_close);
                  else push_decoded(ST_UNKESC, 8'h00);
               end
            endcase
         end
      end else if (ph == PH_HEX1) begin
         if (fin) push_decoded(ST_HEXCUT, 8'h00);
         else begin
            {dec_nib_ok, dec_nib} = hex_digit(b);
            dec_phase = PH_HEX2;
         end
      end else begin
         hx = hex_digit(b);
         if (fin) push_decoded(ST_HEXCUT, 8'h00);
         else if (!dec_nib_ok || !hx[4]) push_decoded(ST_BADHEX, 8'h00);
         else begin
            push_decoded(ST_BYTE, {dec_nib, hx[3:0]});
            dec_nib    = 4'd0;
            dec_nib_ok = 1'b0;
            dec_phase  = PH_BODY;
         end
      end
   endfunction

   // -------------------------------------------------------------- monitoring

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 48);
   endfunction

   // requests are predicted before responses are checked, so a same-edge
   // response never races its own request
   always @(posedge clock) begin : rsp_side
      decoded_type want;
      int unsigned stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_tvalid && req_tready === 1'b1) decode_byte(req_tdata, req_tuser);
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            results_seen++;
            status_hits[rsp_tuser]++;
            if (decoded_q.size() == 0) begin
               $error("unexpected response: status=%0d out_byte=%02h", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_tdata);
                  error_count++;
               end
            end
         end
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: %0d requests still owed a response", decoded_q.size());
      $display("escaped_string_decoder regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_request(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_close(input logic [7:0] v);
      drain();
      dec_close = v;
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      close_writes++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) return CHAR_ZERO + 8'(v);
      return (upper ? UPPER_A : CHAR_A) + 8'(v - 4'd10);
   endfunction

   function automatic logic [7:0] escape_letter(input int unsigned k);
      case (k)
         0: return CHAR_N;
         1: return CHAR_R;
         2: return CHAR_T;
         3: return CHAR_ZERO;
         4: return CHAR_A;
         5: return CHAR_B;
         6: return CHAR_F;
         7: return CHAR_BSL;
         default: return dec_close;
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == dec_close || b == CHAR_BSL);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0, 1:    return CHAR_BSL;
         2:       return CHAR_PCT;
         3:       return dec_close;
         4, 5:    return hex_char(4'($urandom), 1'($urandom));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_hex_escape(input logic [7:0] hi, input logic [7:0] lo);
      send_request(CHAR_BSL, 1'b0);
      send_request(CHAR_PCT, 1'b0);
      send_request(hi, 1'b0);
      send_request(lo, 1'b0);
   endtask

   // one string with every escape, extreme bytes and a leading space
   task automatic test_escapes();
      int unsigned k;
      send_request(CHAR_SPACE, 1'b0);
      send_request(8'hFF, 1'b0);
      for (k = 0; k < 9; k++) begin
         send_request(CHAR_BSL, 1'b0);
         send_request(escape_letter(k), 1'b0);
      end
      send_hex_escape(CHAR_A, UPPER_F);
      send_request(dec_close, 1'b0);
   endtask

   task automatic test_error_statuses();
      send_request(8'h00, 1'b1);                // end before any byte
      send_request(CHAR_BSL, 1'b0);
      send_request(8'hA5, 1'b1);                // end right after backslash
      send_request(CHAR_BSL, 1'b0);
      send_request(CHAR_PCT, 1'b0);
      send_request(8'h00, 1'b1);                // end in place of first digit
      send_request(CHAR_BSL, 1'b0);
      send_request(CHAR_PCT, 1'b0);
      send_request("4", 1'b0);
      send_request(8'hFF, 1'b1);                // end in place of second digit
      send_hex_escape(8'hB0, "1");              // high byte is not a digit
      send_request(CHAR_BSL, 1'b0);
      send_request("q", 1'b0);
      send_request("x", 1'b0);
      send_request(8'h5A, 1'b1);                // unterminated body
   endtask

   task automatic test_close_corners();
      set_close(CHAR_SPACE);                    // first space is still dropped
      send_request(CHAR_SPACE, 1'b0);
      send_request("k", 1'b0);
      send_request(CHAR_SPACE, 1'b0);
      set_close(CHAR_BSL);
      send_request("z", 1'b0);
      send_request(CHAR_BSL, 1'b0);
      set_close(CHAR_N);                        // \n is still a line feed
      send_request(CHAR_BSL, 1'b0);
      send_request(CHAR_N, 1'b0);
      send_request(CHAR_N, 1'b0);
      set_close(CHAR_PCT);                      // \% still starts a hex escape
      send_hex_escape("4", "1");
      send_request(CHAR_PCT, 1'b0);
   endtask

   task automatic random_strings(input int unsigned quota);
      int unsigned first, len, k;
      first = items_sent;
      while (items_sent - first < quota) begin
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 1) != 0) send_request(CHAR_SPACE, 1'b0);
            len = $urandom_range(0, 10);
            for (k = 0; k < len; k++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: send_request(plain_byte(), 1'b0);
                  5, 6, 7: begin
                     send_request(CHAR_BSL, 1'b0);
                     send_request(escape_letter($urandom_range(0, 8)), 1'b0);
                  end
                  default: send_hex_escape(hex_char(4'($urandom), 1'($urandom)),
                                           hex_char(4'($urandom), 1'($urandom)));
               endcase
            end
            if ($urandom_range(0, 9) != 0) send_request(dec_close, 1'b0);
            else send_request(8'($urandom), 1'b1);
         end else begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
               send_request(noise_byte(), $urandom_range(0, 9) == 0);
         end
      end
   endtask

   task automatic test_random_decode();
      int unsigned p;
      logic [7:0]  c;
      for (p = 0; p < 6; p++) begin
         case (p)
            0: c = CLOSE_RESET;
            1: c = 8'h00;
            2: c = 8'hFF;
            3: c = CHAR_BSL;
            4: c = CHAR_SPACE;
            default: c = 8'($urandom);
         endcase
         set_close(c);
         idle_on = (p != 2);                    // one back-to-back stretch
         random_strings(150);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_escapes();
      test_error_statuses();
      test_close_corners();
      test_random_decode();
      drain();
      if (decoded_q.size() != 0) begin
         $error("%0d expected responses never arrived", decoded_q.size());
         error_count++;
      end
      $display("%0d requests decoded into %0d responses across %0d close-byte writes",
               items_sent, results_seen, close_writes);
      $display("responses by status 0..6: %0d %0d %0d %0d %0d %0d %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5], status_hits[6]);
      if (error_count == 0)
         $display("escaped_string_decoder regression: pass");
      else
         $display("escaped_string_decoder regression: fail");
      $finish;
   end

endmodule

// ===== escaped_string_decoder.f =====
+incdir+rtl
rtl/esd_pkg.sv
rtl/esd_decode.sv
rtl/escaped_string_decoder.sv
bench/tb_top.sv
